// File: sv/randomized_set_table_assert.svh
// Assertion macros shared by the randomized set table RTL.
`ifndef RANDOMIZED_SET_TABLE_ASSERT_SVH
`define RANDOMIZED_SET_TABLE_ASSERT_SVH

// Checked outside reset.
`define RSET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define RSET_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/rset_pkg.sv
// Package: constants, codes and types of the randomized set table.
`default_nettype none
package rset_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int ENTRY_W  = VAL_W + 1;
  localparam int RND_W    = 31;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int DSTEP_W  = $clog2(RND_W + 1);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOCHG = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd3;

  typedef struct packed {
    logic             live;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [RND_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: sv/rset_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface rset_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [rset_pkg::KIND_W-1:0]          kind;
  logic signed [rset_pkg::VAL_W-1:0]    value;
  logic [rset_pkg::RND_W-1:0]           random_number;

  modport source(output valid, kind, value, random_number, input ready);
  modport sink(input valid, kind, value, random_number, output ready);
endinterface

interface rset_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [rset_pkg::STAT_W-1:0]          status;
  logic signed [rset_pkg::VAL_W-1:0]    sample_value;

  modport source(output valid, status, sample_value, input ready);
  modport sink(input valid, status, sample_value, output ready);
endinterface
`default_nettype wire

// File: sv/rset_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module rset_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: sv/rset_div.sv
// Bit-serial remainder unit: random number modulo used entry count.
`default_nettype none
module rset_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rset_pkg::div_req_t req,
  output rset_pkg::div_rsp_t      rsp
);
  import rset_pkg::*;

  logic [RND_W-1:0]   dvd_r, dvd_nxt;
  logic [CNT_W-1:0]   dsr_r, dsr_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [DSTEP_W-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W:0]     sh;
  logic [CNT_W:0]     sub;

  always_comb begin
    sh       = {rem_r, dvd_r[RND_W-1]};
    sub      = sh - {1'b0, dsr_r};
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = DSTEP_W'(RND_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[RND_W-2:0], 1'b0};
      rem_nxt = (sh >= {1'b0, dsr_r}) ? sub[CNT_W-1:0] : sh[CNT_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DSTEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r[IDX_W-1:0];
endmodule
`default_nettype wire

// File: sv/randomized_set_table.sv
// Insert and remove: S_SCAN compares entries in order, one table read per cycle, up to used_count;
// a match or the end of the used entries leads to S_RESP.
// Sample: 31-step remainder, then one probe per cycle from that position, skipping dead entries.
// Empty sample and unused kind go straight to S_RESP.
// A new request can be taken in the cycle the result becomes valid; a held output stalls the next result.
// Synchronous reset clears counts and state; entries past used_count are never used.
`default_nettype none
`include "randomized_set_table_assert.svh"
module randomized_set_table (
  input wire logic clk,
  input wire logic rst_n,
  rset_in_if.sink    in_ch,
  rset_out_if.source out_ch
);
  import rset_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [VAL_W-1:0]    value_r, value_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [VAL_W-1:0]    res_sample_r, res_sample_nxt;
  logic [CNT_W-1:0]    issue_idx_r, issue_idx_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    used_count_r, used_count_nxt;
  logic [CNT_W-1:0]    live_count_r, live_count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;
  logic [VAL_W-1:0]    out_sample_r, out_sample_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             accept;
  logic             match;

  // writes happen only on leaving S_SCAN; the next read follows S_RESP and S_IDLE
  rset_ram #(.DEPTH(CAPACITY), .WIDTH(ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rset_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign accept              = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.sample_value = out_sample_r;
  assign match               = cmp_vld_r && (ram_rdata.value == value_r);

  always_comb begin
    state_nxt        = state_r;
    kind_nxt         = kind_r;
    value_nxt        = value_r;
    res_status_nxt   = res_status_r;
    res_sample_nxt   = res_sample_r;
    issue_idx_nxt    = issue_idx_r;
    cmp_idx_nxt      = cmp_idx_r;
    cmp_vld_nxt      = cmp_vld_r;
    pos_nxt          = pos_r;
    used_count_nxt   = used_count_r;
    live_count_nxt   = live_count_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_status_nxt   = out_status_r;
    out_sample_nxt   = out_sample_r;
    ram_we           = 1'b0;
    ram_waddr        = cmp_idx_r;
    ram_wdata.live   = 1'b1;
    ram_wdata.value  = value_r;
    ram_raddr        = pos_r;
    div_req.start    = 1'b0;
    div_req.dividend = in_ch.random_number;
    div_req.divisor  = used_count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt       = in_ch.kind;
          value_nxt      = in_ch.value;
          res_sample_nxt = '0;
          issue_idx_nxt  = '0;
          cmp_vld_nxt    = 1'b0;
          case (in_ch.kind)
            KIND_INSERT, KIND_REMOVE: state_nxt = S_SCAN;
            KIND_SAMPLE: begin
              if (live_count_r == '0 || used_count_r == '0) begin
                res_status_nxt = STAT_EMPTY;
                state_nxt      = S_RESP;
              end else begin
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            default: begin
              res_status_nxt = STAT_NOCHG;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        ram_raddr = issue_idx_r[IDX_W-1:0];
        if (match) begin
          state_nxt      = S_RESP;
          res_status_nxt = STAT_NOCHG;
          if (kind_r == KIND_INSERT) begin
            if (!ram_rdata.live) begin
              ram_we         = 1'b1;
              live_count_nxt = live_count_r + 1'b1;
              res_status_nxt = STAT_DONE;
            end
          end else if (ram_rdata.live) begin
            ram_we         = 1'b1;
            ram_wdata.live = 1'b0;
            live_count_nxt = live_count_r - 1'b1;
            res_status_nxt = STAT_DONE;
          end
        end else if (issue_idx_r < used_count_r) begin
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = issue_idx_r[IDX_W-1:0];
          issue_idx_nxt = issue_idx_r + 1'b1;
        end else begin
          state_nxt      = S_RESP;
          res_status_nxt = STAT_NOCHG;
          if (kind_r == KIND_INSERT) begin
            if (used_count_r == CNT_W'(CAPACITY)) begin
              res_status_nxt = STAT_FULL;
            end else begin
              ram_we         = 1'b1;
              ram_waddr      = used_count_r[IDX_W-1:0];
              used_count_nxt = used_count_r + 1'b1;
              live_count_nxt = live_count_r + 1'b1;
              res_status_nxt = STAT_DONE;
            end
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          pos_nxt     = div_rsp.rem;
          cmp_vld_nxt = 1'b0;
          state_nxt   = S_PROBE;
        end
      end
      S_PROBE: begin
        // read issued at pos_r; the data checked here belongs to the previous position
        if (cmp_vld_r && ram_rdata.live) begin
          res_sample_nxt = ram_rdata.value;
          res_status_nxt = STAT_DONE;
          state_nxt      = S_RESP;
        end else begin
          cmp_vld_nxt = 1'b1;
          if ({1'b0, pos_r} == used_count_r - 1'b1) begin
            pos_nxt = '0;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_sample_nxt = res_sample_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_count_r <= '0;
      live_count_r <= '0;
      out_valid_r  <= 1'b0;
      cmp_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_count_r <= used_count_nxt;
      live_count_r <= live_count_nxt;
      out_valid_r  <= out_valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
    end
    kind_r       <= kind_nxt;
    value_r      <= value_nxt;
    res_status_r <= res_status_nxt;
    res_sample_r <= res_sample_nxt;
    issue_idx_r  <= issue_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_sample_r <= out_sample_nxt;
  end

  `RSET_ASSERT(a_live_le_used, live_count_r <= used_count_r, "live count above used count")
  `RSET_ASSERT(a_used_le_cap, used_count_r <= CNT_W'(CAPACITY), "used count above capacity")
  `RSET_ASSERT(a_state_ok, state_r <= S_RESP, "illegal state code")
  `RSET_ASSERT(a_out_hold, out_valid_r && !out_ch.ready |=> out_valid_r, "result dropped")
  `RSET_ASSERT_RST(a_reset, !rst_n |=> (used_count_r == '0 && !out_valid_r), "reset left state")
endmodule
`default_nettype wire

// File: verif/rset_table_checker.sv
`timescale 1ns / 1ps
// Checker for the set table: tracks every request transfer, predicts its result, compares on output.
module rset_table_checker (
  input  logic clk,
  input  logic rst_n,
  rset_in_if   in_mon,
  rset_out_if  out_mon,
  output int   fail_count,
  output int   pending,
  output int   checked
);
  import rset_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] sample_value;
  } set_result_t;

  logic [VAL_W-1:0] slot_value [CAPACITY];
  bit               slot_live  [CAPACITY];
  int unsigned      used_slots;
  int unsigned      live_slots;
  set_result_t      awaited_results [$];
  set_result_t      oldest;
  int               errs;
  int               seen;

  function automatic int find_slot(logic [VAL_W-1:0] v);
    for (int i = 0; i < used_slots; i++) begin
      if (slot_value[i] == v) return i;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the result it should produce.
  function automatic set_result_t set_outcome(logic [KIND_W-1:0] kind, logic [VAL_W-1:0] v,
                                              logic [RND_W-1:0] rnd);
    set_result_t r;
    int          slot;
    int unsigned pos;
    int unsigned steps;
    r.status       = STAT_NOCHG;
    r.sample_value = '0;
    case (kind)
      KIND_INSERT: begin
        slot = find_slot(v);
        if (slot >= 0) begin
          if (!slot_live[slot]) begin
            slot_live[slot] = 1'b1;
            live_slots++;
            r.status = STAT_DONE;
          end
        end else if (used_slots >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          slot_value[used_slots] = v;
          slot_live[used_slots]  = 1'b1;
          used_slots++;
          live_slots++;
          r.status = STAT_DONE;
        end
      end
      KIND_REMOVE: begin
        slot = find_slot(v);
        if (slot >= 0 && slot_live[slot]) begin
          slot_live[slot] = 1'b0;
          live_slots--;
          r.status = STAT_DONE;
        end
      end
      KIND_SAMPLE: begin
        r.status = STAT_EMPTY;
        if (live_slots != 0) begin
          pos = rnd % used_slots;
          for (steps = 0; steps < used_slots && r.status != STAT_DONE; steps++) begin
            if (slot_live[pos]) begin
              r.status       = STAT_DONE;
              r.sample_value = slot_value[pos];
            end else begin
              pos = (pos + 1 == used_slots) ? 0 : pos + 1;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CAPACITY; i++) slot_live[i] = 1'b0;
      used_slots = 0;
      live_slots = 0;
      awaited_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen++;
        if (awaited_results.size() == 0) begin
          $error("unexpected result transfer: status %0d sample_value %0d",
                 out_mon.status, out_mon.sample_value);
          errs++;
        end else begin
          oldest = awaited_results.pop_front();
          if (out_mon.status !== oldest.status) begin
            $error("status mismatch: expected %0d, actual %0d", oldest.status, out_mon.status);
            errs++;
          end
          if (out_mon.sample_value !== oldest.sample_value) begin
            $error("sample_value mismatch: expected %0d, actual %0d",
                   oldest.sample_value, out_mon.sample_value);
            errs++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        awaited_results = {awaited_results,
                           set_outcome(in_mon.kind, in_mon.value, in_mon.random_number)};
      end
    end
    fail_count <= errs;
    pending    <= awaited_results.size();
    checked    <= seen;
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the set table: clock, reset, request stimulus, result backpressure, verdict.
module tb;
  import rset_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   checked;
  bit   calm;
  bit   hold_req;
  int   sent [4];

  logic [VAL_W-1:0] pool [CAPACITY];
  logic [VAL_W-1:0] strays [$];

  always #1 clk = ~clk;

  rset_in_if  in_ch ();
  rset_out_if out_ch ();

  randomized_set_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  rset_table_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  function automatic logic [RND_W-1:0] pick_rnd();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      2: return RND_W'($urandom_range(200));
      default: return RND_W'($urandom());
    endcase
  endfunction

  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [VAL_W-1:0] v,
                          input logic [RND_W-1:0] rnd);
    if (!calm) begin
      while ($urandom_range(99) < 24) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.value         <= v;
    in_ch.random_number <= rnd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent[kind]++;
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random backpressure unless calm, plus a long hold each time hold_req is set.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 24);
    end
  end

  initial begin
    #2_500_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int               k;
    int               lim;
    int               roll;
    logic [KIND_W-1:0] kd;
    logic [VAL_W-1:0]  v;

    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_INSERT;
    in_ch.value         = '0;
    in_ch.random_number = '0;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < CAPACITY; i++) pool[i] = $urandom();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, extremes, live/dead matches, probe wrap, unused kind
    send_req(KIND_SAMPLE, 32'h1234_5678, 31'd5);
    send_req(KIND_REMOVE, 32'h0000_0000, '0);
    send_req(KIND_UNUSED, 32'hFFFF_FFFF, '1);
    send_req(KIND_INSERT, 32'h8000_0000, '0);
    send_req(KIND_INSERT, 32'h7FFF_FFFF, '0);
    send_req(KIND_INSERT, 32'h0000_0000, '0);
    send_req(KIND_INSERT, 32'hFFFF_FFFF, '0);
    send_req(KIND_INSERT, 32'hFFFF_FFFF, '1);
    send_req(KIND_SAMPLE, 32'h0000_0000, '0);
    send_req(KIND_SAMPLE, 32'h0000_0000, '1);
    send_req(KIND_REMOVE, 32'h0000_0000, '0);
    send_req(KIND_REMOVE, 32'h0000_0000, '0);
    send_req(KIND_SAMPLE, 32'hFFFF_FFFF, 31'd2);
    send_req(KIND_REMOVE, 32'hFFFF_FFFF, '0);
    send_req(KIND_SAMPLE, 32'h0000_0000, 31'd3);
    send_req(KIND_INSERT, 32'h0000_0000, '0);
    send_req(KIND_INSERT, 32'hFFFF_FFFF, '0);
    send_req(KIND_REMOVE, 32'h8000_0000, '0);
    send_req(KIND_REMOVE, 32'h7FFF_FFFF, '0);
    send_req(KIND_REMOVE, 32'h0000_0000, '0);
    send_req(KIND_REMOVE, 32'hFFFF_FFFF, '0);
    send_req(KIND_SAMPLE, 32'h5555_AAAA, 31'd1);
    send_req(KIND_UNUSED, 32'h0000_0000, '0);
    send_req(KIND_INSERT, 32'h7FFF_FFFF, '1);
    send_req(KIND_SAMPLE, 32'h0000_0000, 31'h7FFF_FFFE);
    wait_results();

    // fill: value range widens so the table grows toward capacity
    for (k = 0; k < 350; k++) begin
      lim = 4 + k / 5;
      if (lim > CAPACITY - 1) lim = CAPACITY - 1;
      roll = $urandom_range(99);
      v = pool[$urandom_range(lim)];
      if ($urandom_range(99) < 3) begin
        v = $urandom();
        strays = {strays, v};
      end
      kd = (roll < 52) ? KIND_INSERT : (roll < 75) ? KIND_REMOVE :
           (roll < 96) ? KIND_SAMPLE : KIND_UNUSED;
      if (k == 200) hold_req = 1'b1;
      send_req(kd, v, pick_rnd());
    end
    wait_results();

    // wipe to all tombstones, then sparse samples that may wrap, then refill
    for (k = 0; k < CAPACITY; k++) begin
      send_req(KIND_REMOVE, pool[k], '0);
      if (k % 8 == 7) send_req(KIND_SAMPLE, $urandom(), pick_rnd());
    end
    foreach (strays[i]) send_req(KIND_REMOVE, strays[i], '0);
    send_req(KIND_SAMPLE, '0, pick_rnd());
    send_req(KIND_SAMPLE, '0, '1);
    v = pool[$urandom_range(CAPACITY - 1)];
    send_req(KIND_INSERT, v, '0);
    repeat (6) send_req(KIND_SAMPLE, '0, pick_rnd());
    send_req(KIND_REMOVE, v, '0);
    send_req(KIND_INSERT, pool[0], '0);
    send_req(KIND_INSERT, pool[CAPACITY - 1], '0);
    repeat (4) send_req(KIND_SAMPLE, '0, pick_rnd());
    for (k = 0; k < CAPACITY; k++) send_req(KIND_INSERT, pool[k], '0);
    wait_results();

    // steady state on a full table
    for (k = 0; k < 650; k++) begin
      calm = (k >= 200 && k < 350);
      roll = $urandom_range(99);
      v = pool[$urandom_range(CAPACITY - 1)];
      if ($urandom_range(99) < 8) v = $urandom();
      if (k < 150) begin
        kd = (roll < 25) ? KIND_INSERT : (roll < 70) ? KIND_REMOVE :
             (roll < 96) ? KIND_SAMPLE : KIND_UNUSED;
      end else begin
        kd = (roll < 40) ? KIND_INSERT : (roll < 70) ? KIND_REMOVE :
             (roll < 95) ? KIND_SAMPLE : KIND_UNUSED;
      end
      if (k == 450) hold_req = 1'b1;
      if (k == 550) wait_results();
      send_req(kd, v, pick_rnd());
    end
    calm = 1'b0;

    wait_results();
    repeat (100) @(posedge clk);
    $display("Covered %0d requests (%0d insert, %0d remove, %0d sample, %0d unused kind)",
             sent[KIND_INSERT] + sent[KIND_REMOVE] + sent[KIND_SAMPLE] + sent[KIND_UNUSED],
             sent[KIND_INSERT], sent[KIND_REMOVE], sent[KIND_SAMPLE], sent[KIND_UNUSED]);
    $display("%0d results checked across fill to capacity, tombstone wipe, refill and full table",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
